/* rtl/art_pkg.sv */
// art_pkg: shared types and constants of the acknowledgement/retransmit tracker.
// Depends on nothing; imported by every module of the block.
package art_pkg;

  localparam int ART_ENTRIES = 6;

  localparam logic [7:0]  ACK_TYPE          = 8'hFF;
  localparam logic [10:0] ACK_LEN           = 11'd6;
  localparam logic [7:0]  RESET_MAX_RETRIES = 8'd8;
  localparam int          CFG_DATA_W        = 16;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_TX    = 2'd1,
    OP_TIMER = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    DISP_PASS   = 2'd0,
    DISP_DROP   = 2'd1,
    DISP_URGENT = 2'd2
  } disp_t;

  typedef enum logic [1:0] {
    REG_SESSION_OPEN = 2'd0,
    REG_PHY_ID       = 2'd1,
    REG_MAX_RETRIES  = 2'd2,
    REG_RETRY_DELAY  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_APPLY
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic apply;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic can_load;
  } ctrl_stat_t;

endpackage

/* rtl/art_ctrl.sv */
// art_ctrl: sequencing state machine of the tracker (capture, compare, apply).
// Depends on art_pkg.
module art_ctrl import art_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MATCH;
      end
      ST_MATCH: begin
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (stat.can_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.match   = 1'b0;
    cmd.apply   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MATCH: begin
        cmd.match = 1'b1;
      end
      ST_APPLY: begin
        cmd.apply = stat.can_load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/art_dpath.sv */
// art_dpath: input capture, outstanding-packet table, match vectors and result register.
// Depends on art_pkg; driven by art_ctrl commands.
module art_dpath import art_pkg::*; #(
  parameter int ENTRIES = ART_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output ctrl_stat_t  stat,
  // configuration
  input  logic        session_open,
  input  logic [7:0]  phy_id,
  input  logic [7:0]  max_retries,
  // input transaction
  input  logic [1:0]  opcode,
  input  logic [7:0]  rx_phy,
  input  logic [7:0]  packet_handle,
  input  logic [10:0] packet_length,
  input  logic [7:0]  packet_type,
  input  logic [15:0] serial,
  input  logic        rx_buffer_free,
  input  logic        ack_buffer_free,
  // result transaction
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  disposition,
  output logic        deliver,
  output logic        send_ack,
  output logic [15:0] ack_serial,
  output logic        release_valid,
  output logic [7:0]  release_handle,
  output logic        start_timer,
  output logic [2:0]  free_entries
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int FW = (CW > 3) ? CW : 3;

  // captured transaction
  logic [1:0]  op_q;
  logic [7:0]  phy_q;
  logic [7:0]  handle_q;
  logic [10:0] length_q;
  logic [7:0]  type_q;
  logic [15:0] serial_q;
  logic        rx_free_q;
  logic        ack_free_q;

  // table
  logic               ent_valid   [ENTRIES];
  logic [7:0]         ent_handle  [ENTRIES];
  logic [15:0]        ent_serial  [ENTRIES];
  logic [7:0]         ent_retries [ENTRIES];
  logic [CW-1:0]      free_cnt;
  logic [CW-1:0]      free_cnt_next;

  // compare stage
  logic [ENTRIES-1:0] ser_hit_c, hnd_hit_c, free_vec_c;
  logic [ENTRIES-1:0] ser_hit, hnd_hit, free_vec;
  logic               is_ack, rx_ok;

  // apply stage
  logic [ENTRIES-1:0] ser_oh, hnd_oh, free_oh;
  logic [ENTRIES-1:0] clr_vec, inc_vec, set_vec;
  logic [7:0]         sel_retries, sel_handle;
  logic               at_limit;
  logic [1:0]         disp_n;
  logic               deliver_n, send_ack_n, rel_n, start_n;
  logic [15:0]        ack_serial_n;
  logic [7:0]         rel_handle_n;
  logic [FW-1:0]      free_ext;

  assign stat.can_load = !out_valid || !out_stall;

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q       <= opcode;
      phy_q      <= rx_phy;
      handle_q   <= packet_handle;
      length_q   <= packet_length;
      type_q     <= packet_type;
      serial_q   <= serial;
      rx_free_q  <= rx_buffer_free;
      ack_free_q <= ack_buffer_free;
    end
  end

  // Compare every entry in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ser_hit_c[i]  = ent_valid[i] && (ent_serial[i] == serial_q);
      hnd_hit_c[i]  = ent_valid[i] && (ent_handle[i] == handle_q);
      free_vec_c[i] = !ent_valid[i];
    end
  end

  // Hold the match vectors for the apply cycle
  always_ff @(posedge clk) begin
    if (cmd.match) begin
      ser_hit  <= ser_hit_c;
      hnd_hit  <= hnd_hit_c;
      free_vec <= free_vec_c;
      is_ack   <= (length_q == ACK_LEN) && (type_q == ACK_TYPE);
      rx_ok    <= session_open && (phy_q == phy_id);
    end
  end

  // Lowest set bit of each vector
  assign ser_oh  = ser_hit & (~ser_hit + ENTRIES'(1));
  assign hnd_oh  = hnd_hit & (~hnd_hit + ENTRIES'(1));
  assign free_oh = free_vec & (~free_vec + ENTRIES'(1));

  // Pick the fields of the selected entries
  always_comb begin
    sel_retries = '0;
    sel_handle  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_retries = sel_retries | (ent_retries[i] & {8{hnd_oh[i]}});
      sel_handle  = sel_handle  | (ent_handle[i]  & {8{ser_oh[i]}});
    end
  end

  assign at_limit = sel_retries >= max_retries;

  // Decide the result and the table updates
  always_comb begin
    disp_n       = DISP_PASS;
    deliver_n    = 1'b0;
    send_ack_n   = 1'b0;
    ack_serial_n = '0;
    rel_n        = 1'b0;
    rel_handle_n = '0;
    start_n      = 1'b0;
    clr_vec      = '0;
    inc_vec      = '0;
    set_vec      = '0;
    unique case (op_q)
      OP_RX: begin
        if (rx_ok) begin
          disp_n = DISP_DROP;
          if (is_ack) begin
            rel_n        = |ser_hit;
            rel_handle_n = sel_handle;
            clr_vec      = ser_oh;
          end else if (rx_free_q) begin
            deliver_n = 1'b1;
            if (ack_free_q) begin
              send_ack_n   = 1'b1;
              ack_serial_n = serial_q;
            end
          end
        end
      end
      OP_TX: begin
        if (is_ack) begin
          disp_n = DISP_DROP;
        end else if (|hnd_hit) begin
          if (at_limit) begin
            clr_vec = hnd_oh;
            disp_n  = DISP_DROP;
          end else begin
            inc_vec = hnd_oh;
            start_n = 1'b1;
          end
        end else if (|free_vec) begin
          set_vec = free_oh;
          start_n = 1'b1;
        end else begin
          disp_n = DISP_DROP;
        end
      end
      OP_TIMER: begin
        disp_n = DISP_URGENT;
      end
      default: begin
        disp_n = DISP_PASS;
      end
    endcase
  end

  // Track free entries: a cleared entry adds one, a placed entry takes one
  always_comb begin
    free_cnt_next = free_cnt;
    if (|clr_vec) free_cnt_next = free_cnt + CW'(1);
    else if (|set_vec) free_cnt_next = free_cnt - CW'(1);
  end

  assign free_ext = FW'(free_cnt_next);

  // Update the table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) ent_valid[i] <= 1'b0;
      free_cnt <= CW'(ENTRIES);
    end else if (cmd.apply) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (clr_vec[i]) ent_valid[i] <= 1'b0;
        else if (set_vec[i]) ent_valid[i] <= 1'b1;
      end
      free_cnt <= free_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (set_vec[i]) begin
          ent_handle[i]  <= handle_q;
          ent_serial[i]  <= serial_q;
          ent_retries[i] <= '0;
        end else if (inc_vec[i]) begin
          ent_retries[i] <= ent_retries[i] + 8'd1;
        end
      end
    end
  end

  // Result register: load on apply, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      disposition    <= disp_n;
      deliver        <= deliver_n;
      send_ack       <= send_ack_n;
      ack_serial     <= ack_serial_n;
      release_valid  <= rel_n;
      release_handle <= rel_handle_n;
      start_timer    <= start_n;
      free_entries   <= free_ext[2:0];
    end
  end

endmodule

/* rtl/ack_retransmit_tracker.sv */
// ack_retransmit_tracker: top level with configuration registers, controller and datapath.
// Depends on art_pkg, art_ctrl and art_dpath.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------------------
//   input    | in        | in_valid / in_stall     | opcode .. ack_buffer_free
//   result   | out       | out_valid / out_stall   | disposition .. free_entries
//   config   | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A transaction passes through capture, parallel compare of all table
// entries, then priority pick and table update. The next input is taken in
// the cycle after the update, so no new item is taken before the last is through.
// A stalled result holds the update cycle until the result register frees up;
// a result that waits in the register does not block the next capture.
// Reset clears the table valid bits, the free count and the config registers.
module ack_retransmit_tracker import art_pkg::*; #(
  parameter int ENTRIES = ART_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            opcode,
  input  logic [7:0]            rx_phy,
  input  logic [7:0]            packet_handle,
  input  logic [10:0]           packet_length,
  input  logic [7:0]            packet_type,
  input  logic [15:0]           serial,
  input  logic                  rx_buffer_free,
  input  logic                  ack_buffer_free,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            disposition,
  output logic                  deliver,
  output logic                  send_ack,
  output logic [15:0]           ack_serial,
  output logic                  release_valid,
  output logic [7:0]            release_handle,
  output logic                  start_timer,
  output logic [2:0]            free_entries
);

  logic       session_open;
  logic [7:0] phy_id;
  logic [7:0] max_retries;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  // Configuration registers; the retry interval is held by the external timer
  always_ff @(posedge clk) begin
    if (rst) begin
      session_open <= 1'b0;
      phy_id       <= '0;
      max_retries  <= RESET_MAX_RETRIES;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SESSION_OPEN: session_open <= cfg_data[0];
        REG_PHY_ID:       phy_id       <= cfg_data[7:0];
        REG_MAX_RETRIES:  max_retries  <= cfg_data[7:0];
        REG_RETRY_DELAY:  ;
        default:          ;
      endcase
    end
  end

  art_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  art_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .session_open    (session_open),
    .phy_id          (phy_id),
    .max_retries     (max_retries),
    .opcode          (opcode),
    .rx_phy          (rx_phy),
    .packet_handle   (packet_handle),
    .packet_length   (packet_length),
    .packet_type     (packet_type),
    .serial          (serial),
    .rx_buffer_free  (rx_buffer_free),
    .ack_buffer_free (ack_buffer_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .disposition     (disposition),
    .deliver         (deliver),
    .send_ack        (send_ack),
    .ack_serial      (ack_serial),
    .release_valid   (release_valid),
    .release_handle  (release_handle),
    .start_timer     (start_timer),
    .free_entries    (free_entries)
  );

endmodule

/* rtl/art_checker.sv */
// art_checker: port-level checks on the tracker's result channel, bound to the top level.
// Depends on art_pkg and ack_retransmit_tracker.
module art_checker import art_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  disposition,
  input logic        deliver,
  input logic        send_ack,
  input logic [15:0] ack_serial,
  input logic        release_valid,
  input logic        start_timer
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(disposition) && $stable(ack_serial))
    else $error("stalled result changed");

  // An ACK is only requested for a delivered frame, which is consumed
  a_ack_deliver: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_ack |-> deliver && disposition == DISP_DROP)
    else $error("ack requested without delivery");

  // No ACK serial without an ACK request
  a_ack_serial: assert property (@(posedge clk) disable iff (rst)
    out_valid && !send_ack |-> ack_serial == 16'd0)
    else $error("ack serial set without ack");

  // A release comes from a received ACK, never with a delivery or a timer start
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_valid |-> !deliver && !start_timer && disposition == DISP_DROP)
    else $error("release with conflicting result");

  // Starting the timer means the packet is held
  a_timer: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_timer |-> disposition == DISP_PASS)
    else $error("timer started on a dropped packet");

endmodule

bind ack_retransmit_tracker art_checker u_art_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .disposition   (disposition),
  .deliver       (deliver),
  .send_ack      (send_ack),
  .ack_serial    (ack_serial),
  .release_valid (release_valid),
  .start_timer   (start_timer)
);

/* bench/testbench.sv */
// testbench: directed and random test of ack_retransmit_tracker. A predictor of the
// retransmit table checks every result transaction in order.
// Depends on art_pkg and the RTL of ack_retransmit_tracker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import art_pkg::*;

  localparam int               CLK_HALF          = 5;
  localparam int               CYCLE_LIMIT       = 500000;
  localparam int               SETTLE_CYCLES     = 8;
  localparam int               HOLD_OFF_CYCLES   = 120;
  localparam int               MAX_SHOWN         = 10;
  localparam logic [1:0]       OP_UNUSED         = 2'd3;
  localparam logic [15:0]      RESET_RETRY_DELAY = 16'd1024;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  typedef struct {
    logic [1:0]  opcode;
    logic [7:0]  rx_phy;
    logic [7:0]  packet_handle;
    logic [10:0] packet_length;
    logic [7:0]  packet_type;
    logic [15:0] serial;
    logic        rx_buffer_free;
    logic        ack_buffer_free;
  } pkt_event_t;

  typedef struct packed {
    logic [1:0]  disposition;
    logic        deliver;
    logic        send_ack;
    logic [15:0] ack_serial;
    logic        release_valid;
    logic [7:0]  release_handle;
    logic        start_timer;
    logic [2:0]  free_entries;
  } verdict_t;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index       = REG_SESSION_OPEN;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  in_valid        = 1'b0;
  logic                  in_stall;
  logic [1:0]            opcode          = OP_RX;
  logic [7:0]            rx_phy          = '0;
  logic [7:0]            packet_handle   = '0;
  logic [10:0]           packet_length   = '0;
  logic [7:0]            packet_type     = '0;
  logic [15:0]           serial          = '0;
  logic                  rx_buffer_free  = 1'b0;
  logic                  ack_buffer_free = 1'b0;
  logic                  out_valid;
  logic                  out_stall       = 1'b0;
  logic [1:0]            disposition;
  logic                  deliver;
  logic                  send_ack;
  logic [15:0]           ack_serial;
  logic                  release_valid;
  logic [7:0]            release_handle;
  logic                  start_timer;
  logic [2:0]            free_entries;

  // Predictor copy of the table and the registers
  logic        trk_valid   [ART_ENTRIES];
  logic [7:0]  trk_handle  [ART_ENTRIES];
  logic [15:0] trk_serial  [ART_ENTRIES];
  logic [7:0]  trk_retries [ART_ENTRIES];
  logic        mdl_session;
  logic [7:0]  mdl_phy;
  logic [7:0]  mdl_max_retries;
  logic [15:0] mdl_retry_delay;

  verdict_t expected_q[$];
  int       failures     = 0;
  int       cycle_count  = 0;
  logic     hold_off_req = 1'b0;

  ack_retransmit_tracker dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .opcode          (opcode),
    .rx_phy          (rx_phy),
    .packet_handle   (packet_handle),
    .packet_length   (packet_length),
    .packet_type     (packet_type),
    .serial          (serial),
    .rx_buffer_free  (rx_buffer_free),
    .ack_buffer_free (ack_buffer_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .disposition     (disposition),
    .deliver         (deliver),
    .send_ack        (send_ack),
    .ack_serial      (ack_serial),
    .release_valid   (release_valid),
    .release_handle  (release_handle),
    .start_timer     (start_timer),
    .free_entries    (free_entries)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Apply one packet event to the table copy and return the result it causes
  function automatic verdict_t track_event(input pkt_event_t ev);
    verdict_t v;
    logic     is_ack;
    logic     found;
    int       free_cnt;
    v = '0;
    found = 1'b0;
    free_cnt = 0;
    is_ack = (ev.packet_length == ACK_LEN) && (ev.packet_type == ACK_TYPE);
    case (ev.opcode)
      OP_RX: begin
        if (mdl_session && ev.rx_phy == mdl_phy) begin
          v.disposition = DISP_DROP;
          if (is_ack) begin
            // release the lowest live slot carrying this serial
            for (int i = 0; i < ART_ENTRIES; i++) begin
              if (!found && trk_valid[i] && trk_serial[i] == ev.serial) begin
                found = 1'b1;
                v.release_valid = 1'b1;
                v.release_handle = trk_handle[i];
                trk_valid[i] = 1'b0;
              end
            end
          end else if (ev.rx_buffer_free) begin
            v.deliver = 1'b1;
            if (ev.ack_buffer_free) begin
              v.send_ack = 1'b1;
              v.ack_serial = ev.serial;
            end
          end
        end
      end
      OP_TX: begin
        if (is_ack) begin
          v.disposition = DISP_DROP;
        end else begin
          // count a retry on a known handle, or drop it at the limit
          for (int i = 0; i < ART_ENTRIES; i++) begin
            if (!found && trk_valid[i] && trk_handle[i] == ev.packet_handle) begin
              found = 1'b1;
              if (trk_retries[i] >= mdl_max_retries) begin
                trk_valid[i] = 1'b0;
                v.disposition = DISP_DROP;
              end else begin
                trk_retries[i] = trk_retries[i] + 8'd1;
                v.start_timer = 1'b1;
              end
            end
          end
          // hook a new packet into the lowest free slot
          for (int i = 0; i < ART_ENTRIES; i++) begin
            if (!found && !trk_valid[i]) begin
              found = 1'b1;
              trk_valid[i] = 1'b1;
              trk_handle[i] = ev.packet_handle;
              trk_serial[i] = ev.serial;
              trk_retries[i] = 8'd0;
              v.start_timer = 1'b1;
            end
          end
          if (!found) begin
            v.disposition = DISP_DROP;
          end
        end
      end
      OP_TIMER: begin
        v.disposition = DISP_URGENT;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < ART_ENTRIES; i++) begin
      if (!trk_valid[i]) free_cnt++;
    end
    v.free_entries = 3'(free_cnt);
    return v;
  endfunction

  function automatic pkt_event_t make_event(input logic [1:0] op, input logic [7:0] phy,
                                            input logic [7:0] handle, input logic [10:0] len,
                                            input logic [7:0] ptype, input logic [15:0] ser,
                                            input logic rxf, input logic ackf);
    pkt_event_t ev;
    ev.opcode = op;
    ev.rx_phy = phy;
    ev.packet_handle = handle;
    ev.packet_length = len;
    ev.packet_type = ptype;
    ev.serial = ser;
    ev.rx_buffer_free = rxf;
    ev.ack_buffer_free = ackf;
    return ev;
  endfunction

  function automatic string verdict_text(input verdict_t v);
    return $sformatf("disp=%0d deliver=%b ack=%b/%h release=%b/%h timer=%b free=%0d",
                     v.disposition, v.deliver, v.send_ack, v.ack_serial, v.release_valid,
                     v.release_handle, v.start_timer, v.free_entries);
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= MAX_SHOWN) $display("%s", what);
  endfunction

  // Build a mostly well-formed event from the current table contents
  function automatic pkt_event_t pick_event();
    pkt_event_t ev;
    int         roll;
    int         live[$];
    for (int i = 0; i < ART_ENTRIES; i++) begin
      if (trk_valid[i]) live.push_back(i);
    end
    ev = make_event(OP_TIMER, mdl_phy, 8'($urandom_range(0, 15)),
                    11'($urandom_range(0, 2047)), 8'($urandom_range(0, 254)),
                    16'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) ev.serial = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      // transmit complete: retry a live handle or hook a new one
      ev.opcode = OP_TX;
      if (live.size() != 0 && $urandom_range(0, 99) < 60) begin
        ev.packet_handle = trk_handle[live[$urandom_range(0, live.size() - 1)]];
      end else if ($urandom_range(0, 4) == 0) begin
        ev.packet_handle = 8'($urandom);
      end
      if ($urandom_range(0, 19) == 0) begin
        ev.packet_length = ACK_LEN;
        ev.packet_type = ACK_TYPE;
      end
    end else if (roll < 65) begin
      // received ACK, mostly for a live serial
      ev.opcode = OP_RX;
      ev.packet_length = ACK_LEN;
      ev.packet_type = ACK_TYPE;
      if (live.size() != 0 && $urandom_range(0, 99) < 75) begin
        ev.serial = trk_serial[live[$urandom_range(0, live.size() - 1)]];
      end
      if ($urandom_range(0, 9) == 0) ev.rx_phy = 8'($urandom);
    end else if (roll < 80) begin
      ev.opcode = OP_RX;
      if ($urandom_range(0, 99) < 15) ev.rx_phy = 8'($urandom);
    end else if (roll >= 90) begin
      // noise across every field
      ev = make_event(2'($urandom_range(OP_RX, OP_TIMER)), 8'($urandom), 8'($urandom),
                      11'($urandom), 8'($urandom), 16'($urandom), 1'($urandom),
                      1'($urandom));
    end
    return ev;
  endfunction

  // Offer one transaction and hold it until the block takes it
  task automatic send_event(input pkt_event_t ev);
    in_valid <= 1'b1;
    opcode <= ev.opcode;
    rx_phy <= ev.rx_phy;
    packet_handle <= ev.packet_handle;
    packet_length <= ev.packet_length;
    packet_type <= ev.packet_type;
    serial <= ev.serial;
    rx_buffer_free <= ev.rx_buffer_free;
    ack_buffer_free <= ev.ack_buffer_free;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(track_event(ev));
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Wait for every expected result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_SESSION_OPEN: mdl_session = d[0];
      REG_PHY_ID:       mdl_phy = d[7:0];
      REG_MAX_RETRIES:  mdl_max_retries = d[7:0];
      REG_RETRY_DELAY:  mdl_retry_delay = d[15:0];
      default: begin
      end
    endcase
  endtask

  task automatic program_tracker(input logic sess, input logic [7:0] phy,
                                 input logic [7:0] retries, input logic [15:0] delay);
    write_reg(REG_SESSION_OPEN, CFG_DATA_W'(sess));
    write_reg(REG_PHY_ID, CFG_DATA_W'(phy));
    write_reg(REG_MAX_RETRIES, CFG_DATA_W'(retries));
    write_reg(REG_RETRY_DELAY, CFG_DATA_W'(delay));
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: frames pass while no session is open, tx and timer still act
  task automatic test_closed_session();
    send_event(make_event(OP_RX, 8'h00, 8'h00, 11'd64, 8'h01, 16'h0001, 1'b1, 1'b1));
    send_event(make_event(OP_RX, 8'h00, 8'h00, ACK_LEN, ACK_TYPE, 16'h0010, 1'b1, 1'b1));
    send_event(make_event(OP_TX, 8'h00, 8'h10, 11'd100, 8'h02, 16'h0010, 1'b0, 1'b0));
    send_event(make_event(OP_TIMER, 8'h00, 8'h10, 11'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
    drain();
  endtask

  task automatic test_directed_table();
    program_tracker(1'b1, 8'hA5, 8'd1, 16'hFFFF);
    // foreign interface passes through
    send_event(make_event(OP_RX, 8'h5A, 8'h00, 11'd40, 8'h01, 16'h0100, 1'b1, 1'b1));
    // hook two packets at the field extremes, then retry one up to the limit
    send_event(make_event(OP_TX, 8'h00, 8'h00, 11'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_TX, 8'hFF, 8'hFF, 11'd2047, 8'hFE, 16'hFFFF, 1'b1, 1'b1));
    send_event(make_event(OP_TX, 8'h00, 8'h00, 11'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
    send_event(make_event(OP_TX, 8'h00, 8'h00, 11'd0, 8'h00, 16'h0000, 1'b0, 1'b0));
    // transmitted ACK, timer expiry, unused opcode
    send_event(make_event(OP_TX, 8'hA5, 8'h33, ACK_LEN, ACK_TYPE, 16'h0033, 1'b0, 1'b0));
    send_event(make_event(OP_TIMER, 8'hA5, 8'hFF, 11'd10, 8'h00, 16'hFFFF, 1'b0, 1'b0));
    send_event(make_event(OP_UNUSED, 8'hA5, 8'h01, 11'd10, 8'h00, 16'h0001, 1'b1, 1'b1));
    // received ACK with and without a match
    send_event(make_event(OP_RX, 8'hA5, 8'h00, ACK_LEN, ACK_TYPE, 16'hFFFF, 1'b0, 1'b0));
    send_event(make_event(OP_RX, 8'hA5, 8'h00, ACK_LEN, ACK_TYPE, 16'h7777, 1'b1, 1'b1));
    // data frames under each buffer combination, and near-ACK shapes
    send_event(make_event(OP_RX, 8'hA5, 8'h00, 11'd2047, 8'h00, 16'hFFFF, 1'b1, 1'b1));
    send_event(make_event(OP_RX, 8'hA5, 8'h00, 11'd12, 8'h10, 16'h1111, 1'b1, 1'b0));
    send_event(make_event(OP_RX, 8'hA5, 8'h00, 11'd12, 8'h10, 16'h2222, 1'b0, 1'b1));
    send_event(make_event(OP_RX, 8'hA5, 8'h00, ACK_LEN, 8'hFE, 16'h3333, 1'b1, 1'b1));
    send_event(make_event(OP_RX, 8'hA5, 8'h00, 11'd7, ACK_TYPE, 16'h4444, 1'b1, 1'b1));
    // fill the table, then release the lowest of two equal serials
    for (int h = 1; h <= ART_ENTRIES; h++) begin
      send_event(make_event(OP_TX, 8'h00, 8'(h), 11'd50, 8'h03,
                            (h < 3) ? 16'h1234 : 16'(h), 1'b0, 1'b0));
    end
    send_event(make_event(OP_RX, 8'hA5, 8'h00, ACK_LEN, ACK_TYPE, 16'h1234, 1'b0, 1'b0));
    drain();
  endtask

  // Random traffic in bursts; gap_max of zero keeps the sender busy throughout
  task automatic test_random_traffic(input int count, input int gap_max);
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < count; n++) begin
      send_event(pick_event());
      if (gap_max > 0) begin
        if (burst_left == 0) begin
          pause_sender($urandom_range(1, gap_max));
          burst_left = $urandom_range(1, 24);
        end else begin
          burst_left--;
        end
      end
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    program_tracker(1'b1, 8'h5A, 8'd3, RESET_RETRY_DELAY);
    hold_off_req = 1'b1;
    for (int n = 0; n < 60; n++) begin
      send_event(pick_event());
    end
    drain();
  endtask

  // Receiver stall pattern, with the long hold-off on request
  initial begin
    stall_style_t style;
    int           left;
    int           phase;
    style = STALL_NONE;
    left = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          style = stall_style_t'($urandom_range(STALL_NONE, STALL_HEAVY));
          left = $urandom_range(20, 200);
        end
        left--;
        phase++;
        case (style)
          STALL_NONE:     out_stall <= 1'b0;
          STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
          STALL_PERIODIC: out_stall <= ((phase % 5) < 2);
          default:        out_stall <= ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {disposition, deliver, send_ack, ack_serial, release_valid, release_handle,
             start_timer, free_entries};
      if (expected_q.size() == 0) begin
        note_failure({"unexpected result: ", verdict_text(got)});
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          note_failure({"mismatch: expected ", verdict_text(want), " got ", verdict_text(got)});
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    for (int i = 0; i < ART_ENTRIES; i++) begin
      trk_valid[i] = 1'b0;
      trk_handle[i] = '0;
      trk_serial[i] = '0;
      trk_retries[i] = '0;
    end
    mdl_session = 1'b0;
    mdl_phy = 8'h00;
    mdl_max_retries = RESET_MAX_RETRIES;
    mdl_retry_delay = RESET_RETRY_DELAY;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_closed_session();
    test_directed_table();
    program_tracker(1'b1, 8'hA5, 8'd2, 16'h0000);
    test_random_traffic(300, 6);
    program_tracker(1'b1, 8'h00, 8'd0, 16'hFFFF);
    test_random_traffic(250, 0);
    program_tracker(1'b1, 8'hFF, 8'd255, RESET_RETRY_DELAY);
    test_random_traffic(250, 10);
    program_tracker(1'b0, 8'h3C, 8'd1, 16'h8001);
    test_random_traffic(150, 4);
    program_tracker(1'b1, 8'($urandom), 8'($urandom_range(1, 4)), 16'($urandom));
    test_random_traffic(300, 3);
    test_backpressure();
    program_tracker(1'b1, 8'h81, RESET_MAX_RETRIES, 16'h0001);
    test_random_traffic(300, 8);

    if (failures == 0 && expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
